>>> rtl/ebce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebce_pkg
// Shared constants, types and helper functions of the execute block.
// ----------------------------------------------------------------------------
package ebce_pkg;

    localparam int STACK_DEPTH = 7;
    localparam int SP_W        = 3;
    localparam int PC_W        = 14;

    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_H = 3'd5;
    localparam logic [2:0] REG_L = 3'd6;
    localparam logic [2:0] REG_M = 3'd7;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_UNKNOWN   = 2'd1,
        FAULT_OVERFLOW  = 2'd2,
        FAULT_UNDERFLOW = 2'd3
    } t_fault;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBB = 3'd3,
        ALU_AND = 3'd4,
        ALU_XOR = 3'd5,
        ALU_OR  = 3'd6,
        ALU_CMP = 3'd7
    } t_alu_op;

    // Result of the ALU: new accumulator and flags.
    typedef struct packed {
        logic [7:0] acc;
        logic [3:0] flags;
    } t_alu_res;

    // Zero, sign and even parity bits for a byte; carry left clear.
    function automatic logic [3:0] zsp_of(input logic [7:0] v);
        logic [3:0] f;
        f    = 4'd0;
        f[1] = (v == 8'd0);
        f[2] = v[7];
        f[3] = ~(^v);
        return f;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ebce_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebce_alu
// Eight-bit arithmetic and logic unit with flag generation.
// ----------------------------------------------------------------------------
module ebce_alu (
    input  wire logic [2:0]       i_sel,
    input  wire logic [7:0]       i_a,
    input  wire logic [7:0]       i_v,
    input  wire logic             i_cin,
    output ebce_pkg::t_alu_res    o_res
);
    import ebce_pkg::*;

    logic [8:0] sum;
    logic [7:0] r;
    logic       cy;

    always_comb begin
        sum = 9'd0;
        r   = i_a;
        cy  = 1'b0;
        case (t_alu_op'(i_sel))
            ALU_ADD: begin
                sum = {1'b0, i_a} + {1'b0, i_v};
                r = sum[7:0]; cy = sum[8];
            end
            ALU_ADC: begin
                sum = {1'b0, i_a} + {1'b0, i_v} + {8'd0, i_cin};
                r = sum[7:0]; cy = sum[8];
            end
            ALU_SUB, ALU_CMP: begin
                sum = {1'b0, i_a} - {1'b0, i_v};
                r = sum[7:0]; cy = sum[8];
            end
            ALU_SBB: begin
                sum = {1'b0, i_a} - {1'b0, i_v} - {8'd0, i_cin};
                r = sum[7:0]; cy = sum[8];
            end
            ALU_AND: r = i_a & i_v;
            ALU_XOR: r = i_a ^ i_v;
            ALU_OR:  r = i_a | i_v;
            default: r = i_a;
        endcase
        o_res.flags = zsp_of(r) | {3'd0, cy};
        o_res.acc   = (t_alu_op'(i_sel) == ALU_CMP) ? i_a : r;
    end

endmodule
`default_nettype wire

>>> rtl/eight_bit_cpu_execute.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute
// Executes one 8008-style instruction per input transfer.
// ----------------------------------------------------------------------------
// The input channel carries an instruction: opcode, the two bytes after it
// and the memory byte at the current H:L address. Each input transfer yields
// exactly one result transfer with the next program counter, any memory
// store, the accumulator, flags, instruction length, halt and fault code.
// The instruction is captured into an input register, decoded and executed
// by one pass of combinational logic, and the architectural state and the
// result register are updated at the edge on which it moves on to the result
// register. Throughput is one instruction per cycle while the receiver is
// ready, since the state update of one instruction is complete before the
// next one is executed. The input stage accepts whenever it is empty or its
// item moves on in the same cycle, so a stalled receiver only fills the
// result register and then the input register before ready falls.
// Reset clears registers, flags, program counter, stack pointer and halt;
// the return stack contents are left as they are, since only entries below
// the stack pointer are ever read.
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_opcode,
    input  wire logic [7:0]  i_second_byte,
    input  wire logic [7:0]  i_third_byte,
    input  wire logic [7:0]  i_mem_read_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [13:0]      o_next_pc,
    output logic [13:0]      o_mem_addr,
    output logic             o_mem_write,
    output logic [7:0]       o_mem_write_data,
    output logic [7:0]       o_accumulator_out,
    output logic [3:0]       o_flags_out,
    output logic [1:0]       o_bytes_used,
    output logic             o_halted_out,
    output logic [1:0]       o_fault
);
    import ebce_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_op, r_b1, r_b2, r_mem;

    // Architectural state.
    logic [7:0]      r_regs [0:6];
    logic [PC_W-1:0] r_pc;
    logic [3:0]      r_flags;
    logic [PC_W-1:0] r_stack [0:STACK_DEPTH-1];
    logic [SP_W-1:0] r_sp;
    logic            r_halted;

    // Next state.
    logic [7:0]      n_regs [0:6];
    logic [PC_W-1:0] n_pc;
    logic [3:0]      n_flags;
    logic [SP_W-1:0] n_sp;
    logic            n_halted;
    logic            push_en;
    logic [PC_W-1:0] push_val;

    // Result values.
    logic [PC_W-1:0] n_addr;
    logic            n_memw;
    logic [7:0]      n_wdata;
    logic [1:0]      n_len;
    t_fault          n_fault;

    logic exec, out_free;

    assign out_free = ~o_valid | i_ready;
    assign exec     = r_in_valid & out_free;
    assign o_ready  = ~r_in_valid | out_free;

    // ALU operand select.
    logic [2:0] ddd, sss;
    logic [7:0] alu_v;
    logic       cond;
    t_alu_res   alu_res;

    assign ddd  = r_op[5:3];
    assign sss  = r_op[2:0];
    assign cond = (r_flags[ddd[1:0]] == ddd[2]);

    always_comb begin
        if (r_op[7:6] == 2'b00) alu_v = r_b1;
        else if (sss == REG_M) alu_v = r_mem;
        else alu_v = r_regs[sss];
    end

    ebce_alu u_alu (
        .i_sel (ddd),
        .i_a   (r_regs[REG_A]),
        .i_v   (alu_v),
        .i_cin (r_flags[0]),
        .o_res (alu_res)
    );

    logic [PC_W-1:0] pc1, pc2, pc3, target, pop_val;
    logic            sp_empty, sp_full;
    logic [7:0]      incdec, rot_a;
    logic            rot_c;

    assign pc1      = r_pc + PC_W'(1);
    assign pc2      = r_pc + PC_W'(2);
    assign pc3      = r_pc + PC_W'(3);
    assign target   = {r_b2[5:0], r_b1};
    assign sp_empty = (r_sp == '0);
    assign sp_full  = (r_sp >= SP_W'(STACK_DEPTH));
    assign pop_val  = r_stack[r_sp - SP_W'(1)];

    always_comb begin
        for (int i = 0; i < 7; i++) n_regs[i] = r_regs[i];
        n_pc     = pc1;
        n_flags  = r_flags;
        n_sp     = r_sp;
        n_halted = r_halted;
        push_en  = 1'b0;
        push_val = pc1;
        n_addr   = {r_regs[REG_H][5:0], r_regs[REG_L]};
        n_memw   = 1'b0;
        n_wdata  = 8'd0;
        n_len    = 2'd1;
        n_fault  = FAULT_NONE;
        incdec   = r_regs[ddd] + ((sss == 3'd0) ? 8'd1 : 8'hff);
        rot_a    = r_regs[REG_A];
        rot_c    = r_flags[0];
        case (ddd)
            3'd0: begin rot_a = {r_regs[REG_A][6:0], r_regs[REG_A][7]}; rot_c = r_regs[REG_A][7]; end
            3'd1: begin rot_a = {r_regs[REG_A][0], r_regs[REG_A][7:1]}; rot_c = r_regs[REG_A][0]; end
            3'd2: begin rot_a = {r_regs[REG_A][6:0], r_flags[0]}; rot_c = r_regs[REG_A][7]; end
            3'd3: begin rot_a = {r_flags[0], r_regs[REG_A][7:1]}; rot_c = r_regs[REG_A][0]; end
            default: ;
        endcase

        if (r_halted) begin
            n_pc = r_pc;
        end else begin
            case (r_op[7:6])
                2'b00: begin
                    if (r_op[7:1] == 7'd0) begin
                        n_halted = 1'b1;
                    end else begin
                        case (sss)
                            3'd0, 3'd1: begin
                                if (ddd == REG_M) n_fault = FAULT_UNKNOWN;
                                else begin
                                    n_regs[ddd] = incdec;
                                    n_flags = zsp_of(incdec) | {3'd0, r_flags[0]};
                                end
                            end
                            3'd2: begin
                                if (ddd[2]) n_fault = FAULT_UNKNOWN;
                                else begin
                                    n_regs[REG_A] = rot_a;
                                    n_flags[0] = rot_c;
                                end
                            end
                            3'd3: begin
                                if (cond) begin
                                    if (sp_empty) n_fault = FAULT_UNDERFLOW;
                                    else begin
                                        n_sp = r_sp - SP_W'(1);
                                        n_pc = pop_val;
                                    end
                                end
                            end
                            3'd4: begin
                                n_len = 2'd2;
                                n_pc = pc2;
                                n_regs[REG_A] = alu_res.acc;
                                n_flags = alu_res.flags;
                            end
                            3'd5: begin
                                if (sp_full) n_fault = FAULT_OVERFLOW;
                                else begin
                                    push_en = 1'b1;
                                    n_sp = r_sp + SP_W'(1);
                                end
                                n_pc = {8'd0, ddd, 3'd0};
                            end
                            3'd6: begin
                                n_len = 2'd2;
                                n_pc = pc2;
                                if (ddd == REG_M) begin
                                    n_memw = 1'b1;
                                    n_wdata = r_b1;
                                end else n_regs[ddd] = r_b1;
                            end
                            default: begin
                                if (sp_empty) n_fault = FAULT_UNDERFLOW;
                                else begin
                                    n_sp = r_sp - SP_W'(1);
                                    n_pc = pop_val;
                                end
                            end
                        endcase
                    end
                end
                2'b01: begin
                    if (!sss[0]) begin
                        n_len = 2'd3;
                        n_pc = pc3;
                        if (sss == 3'd4 || (sss == 3'd0 && cond)) begin
                            n_pc = target;
                        end else if (sss == 3'd6 || (sss == 3'd2 && cond)) begin
                            push_val = pc3;
                            if (sp_full) n_fault = FAULT_OVERFLOW;
                            else begin
                                push_en = 1'b1;
                                n_sp = r_sp + SP_W'(1);
                            end
                            n_pc = target;
                        end
                    end
                end
                2'b10: begin
                    n_regs[REG_A] = alu_res.acc;
                    n_flags = alu_res.flags;
                end
                default: begin
                    if (r_op == 8'hff) n_halted = 1'b1;
                    else if (sss == REG_M) n_regs[ddd] = r_mem;
                    else if (ddd == REG_M) begin
                        n_memw = 1'b1;
                        n_wdata = r_regs[sss];
                    end else n_regs[ddd] = r_regs[sss];
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op  <= i_opcode;
            r_b1  <= i_second_byte;
            r_b2  <= i_third_byte;
            r_mem <= i_mem_read_data;
        end
    end

    // Architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 7; i++) r_regs[i] <= 8'd0;
            r_pc     <= '0;
            r_flags  <= 4'd0;
            r_sp     <= '0;
            r_halted <= 1'b0;
        end else if (exec) begin
            for (int i = 0; i < 7; i++) r_regs[i] <= n_regs[i];
            r_pc     <= n_pc;
            r_flags  <= n_flags;
            r_sp     <= n_sp;
            r_halted <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && push_en) begin
            r_stack[r_sp] <= push_val;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_free) begin
            o_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            o_next_pc         <= n_pc;
            o_mem_addr        <= n_addr;
            o_mem_write       <= n_memw;
            o_mem_write_data  <= n_wdata;
            o_accumulator_out <= n_regs[REG_A];
            o_flags_out       <= n_flags;
            o_bytes_used      <= n_len;
            o_halted_out      <= n_halted;
            o_fault           <= n_fault;
        end
    end

    // Stack pointer never passes the stack depth.
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer out of range");

    // Once halted, the state stays halted until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt cleared without reset");

    // A store is only reported together with no fault.
    a_memw_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mem_write) |-> (o_fault == FAULT_NONE))
        else $error("store reported with fault");

endmodule
`default_nettype wire

>>> sim/tb_eight_bit_cpu_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eight_bit_cpu_execute
// Self-checking testbench for the 8008-style instruction execute block.
// ----------------------------------------------------------------------------
// Instructions are sent over the input channel with random gaps, and every
// result transfer is compared field by field against a cycle-free model of
// the processor state kept inside this testbench. Directed tests cover the
// instruction groups and the special cases; a long random test runs before the halt test.
// ----------------------------------------------------------------------------
module tb_eight_bit_cpu_execute;
    import ebce_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_opcode;
    logic [7:0]  i_second_byte;
    logic [7:0]  i_third_byte;
    logic [7:0]  i_mem_read_data;
    logic        o_valid;
    logic        i_ready;
    logic [13:0] o_next_pc;
    logic [13:0] o_mem_addr;
    logic        o_mem_write;
    logic [7:0]  o_mem_write_data;
    logic [7:0]  o_accumulator_out;
    logic [3:0]  o_flags_out;
    logic [1:0]  o_bytes_used;
    logic        o_halted_out;
    logic [1:0]  o_fault;

    eight_bit_cpu_execute DUT (.*);

    // One expected result of an executed instruction.
    typedef struct packed {
        logic [13:0] next_pc;
        logic [13:0] mem_addr;
        logic        mem_write;
        logic [7:0]  mem_write_data;
        logic [7:0]  acc;
        logic [3:0]  flags;
        logic [1:0]  bytes_used;
        logic        halted;
        t_fault      fault;
    } t_exec_result;

    t_exec_result expected_results[$];
    int           error_count;
    bit           no_idle;

    // Architectural state of the processor as predicted by the testbench.
    logic [7:0]  cpu_regs[7];
    logic [13:0] cpu_pc;
    logic [3:0]  cpu_flags;
    logic [13:0] cpu_stack[STACK_DEPTH];
    int          cpu_sp;
    logic        cpu_halted;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [3:0] parity_flags(input logic [7:0] v);
        logic [3:0] f;
        f    = 4'd0;
        f[1] = (v == 8'd0);
        f[2] = v[7];
        f[3] = ~(^v);
        return f;
    endfunction

    // Runs one ALU operation on the accumulator; compare keeps A.
    function automatic void run_alu(input t_alu_op sel, input logic [7:0] v);
        logic [8:0] r;
        logic       cy;
        logic       cin;
        cin = cpu_flags[0];
        cy  = 1'b0;
        case (sel)
            ALU_ADD: begin r = cpu_regs[REG_A] + v; cy = r[8]; end
            ALU_ADC: begin r = cpu_regs[REG_A] + v + cin; cy = r[8]; end
            ALU_SUB, ALU_CMP: begin
                r  = cpu_regs[REG_A] - v;
                cy = cpu_regs[REG_A] < v;
            end
            ALU_SBB: begin
                r  = cpu_regs[REG_A] - v - cin;
                cy = {1'b0, cpu_regs[REG_A]} < ({1'b0, v} + cin);
            end
            ALU_AND: r = cpu_regs[REG_A] & v;
            ALU_XOR: r = cpu_regs[REG_A] ^ v;
            default: r = cpu_regs[REG_A] | v;
        endcase
        cpu_flags = parity_flags(r[7:0]) | {3'b0, cy};
        if (sel != ALU_CMP) cpu_regs[REG_A] = r[7:0];
    endfunction

    function automatic t_fault push_return(input logic [13:0] v);
        if (cpu_sp >= STACK_DEPTH) return FAULT_OVERFLOW;
        cpu_stack[cpu_sp] = v;
        cpu_sp++;
        return FAULT_NONE;
    endfunction

    function automatic logic [13:0] pop_return(input logic [13:0] fallback,
                                               inout t_fault flt);
        if (cpu_sp == 0) begin
            flt = FAULT_UNDERFLOW;
            return fallback;
        end
        cpu_sp--;
        return cpu_stack[cpu_sp];
    endfunction

    // Executes one instruction on the predicted state and returns its result.
    function automatic t_exec_result execute_instr(input logic [7:0] op, input logic [7:0] b1,
                                                   input logic [7:0] b2, input logic [7:0] mem);
        t_exec_result res;
        logic [13:0]  pc1, nxt;
        logic [2:0]   ddd, sss;
        logic         cond, hi, lo, c;
        logic [7:0]   a;
        t_fault       flt;
        res      = '0;
        ddd      = op[5:3];
        sss      = op[2:0];
        pc1      = cpu_pc + 14'd1;
        nxt      = pc1;
        flt      = FAULT_NONE;
        cond     = cpu_flags[ddd[1:0]] == ddd[2];
        res.mem_addr   = {cpu_regs[REG_H][5:0], cpu_regs[REG_L]};
        res.bytes_used = 2'd1;
        if (cpu_halted) begin
            nxt = cpu_pc;
        end else begin
            case (op[7:6])
                2'd0: begin
                    if (op <= 8'd1) begin
                        cpu_halted = 1'b1;
                    end else begin
                        case (sss)
                            3'd0, 3'd1: begin
                                if (ddd == REG_M) begin
                                    flt = FAULT_UNKNOWN;
                                end else begin
                                    cpu_regs[ddd] = cpu_regs[ddd] + ((sss == 3'd0) ? 8'd1 : 8'hff);
                                    cpu_flags = parity_flags(cpu_regs[ddd])
                                                | {3'b0, cpu_flags[0]};
                                end
                            end
                            3'd2: begin
                                a  = cpu_regs[REG_A];
                                hi = a[7];
                                lo = a[0];
                                c  = cpu_flags[0];
                                case (ddd)
                                    3'd0: begin a = {a[6:0], hi}; c = hi; end
                                    3'd1: begin a = {lo, a[7:1]}; c = lo; end
                                    3'd2: begin a = {a[6:0], c}; c = hi; end
                                    3'd3: begin a = {c, a[7:1]}; c = lo; end
                                    default: flt = FAULT_UNKNOWN;
                                endcase
                                cpu_regs[REG_A] = a;
                                cpu_flags[0]    = c;
                            end
                            3'd3: if (cond) nxt = pop_return(pc1, flt);
                            3'd4: begin
                                res.bytes_used = 2'd2;
                                nxt = cpu_pc + 14'd2;
                                run_alu(t_alu_op'(ddd), b1);
                            end
                            3'd5: begin
                                flt = push_return(pc1);
                                nxt = {8'd0, ddd, 3'd0};
                            end
                            3'd6: begin
                                res.bytes_used = 2'd2;
                                nxt = cpu_pc + 14'd2;
                                if (ddd == REG_M) begin
                                    res.mem_write      = 1'b1;
                                    res.mem_write_data = b1;
                                end else begin
                                    cpu_regs[ddd] = b1;
                                end
                            end
                            default: nxt = pop_return(pc1, flt);
                        endcase
                    end
                end
                2'd1: begin
                    // Odd low bits are the I/O instructions, executed as no-ops.
                    if (!sss[0]) begin
                        res.bytes_used = 2'd3;
                        nxt = cpu_pc + 14'd3;
                        if (sss == 3'd4 || (sss == 3'd0 && cond)) begin
                            nxt = {b2[5:0], b1};
                        end else if (sss == 3'd6 || (sss == 3'd2 && cond)) begin
                            flt = push_return(nxt);
                            nxt = {b2[5:0], b1};
                        end
                    end
                end
                2'd2: run_alu(t_alu_op'(ddd), (sss == REG_M) ? mem : cpu_regs[sss]);
                default: begin
                    if (op == 8'hff) begin
                        cpu_halted = 1'b1;
                    end else if (sss == REG_M) begin
                        cpu_regs[ddd] = mem;
                    end else if (ddd == REG_M) begin
                        res.mem_write      = 1'b1;
                        res.mem_write_data = cpu_regs[sss];
                    end else begin
                        cpu_regs[ddd] = cpu_regs[sss];
                    end
                end
            endcase
            cpu_pc = nxt;
        end
        res.next_pc = nxt;
        res.acc     = cpu_regs[REG_A];
        res.flags   = cpu_flags;
        res.halted  = cpu_halted;
        res.fault   = flt;
        return res;
    endfunction

    // Sends one instruction as a single input transfer. Valid stays high
    // after the transfer so that back-to-back items leave no gap; it drops
    // only while the sender idles.
    task automatic send_instr(input logic [7:0] op, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] mem);
        if (!no_idle && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (!no_idle && $urandom_range(99) < 9) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_second_byte   <= b1;
        i_third_byte    <= b2;
        i_mem_read_data <= mem;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(execute_instr(op, b1, b2, mem));
    endtask

    // The receiver stalls at random except during the quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= no_idle || ($urandom_range(99) >= 9);
    end

    // Each result transfer is checked against the oldest expected result.
    always @(posedge i_clk) begin
        t_exec_result exp_r;
        t_exec_result act_r;
        if (i_rst_n && o_valid && i_ready) begin
            act_r = {o_next_pc, o_mem_addr, o_mem_write, o_mem_write_data,
                     o_accumulator_out, o_flags_out, o_bytes_used, o_halted_out,
                     t_fault'(o_fault)};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, act_r);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (act_r.next_pc !== exp_r.next_pc) begin
                    $display("%0t: next_pc exp %h got %h", $time, exp_r.next_pc, act_r.next_pc);
                    error_count++;
                end
                if (act_r.mem_addr !== exp_r.mem_addr) begin
                    $display("%0t: mem_addr exp %h got %h", $time, exp_r.mem_addr,
                             act_r.mem_addr);
                    error_count++;
                end
                if (act_r.mem_write !== exp_r.mem_write) begin
                    $display("%0t: mem_write exp %b got %b", $time, exp_r.mem_write,
                             act_r.mem_write);
                    error_count++;
                end
                if (act_r.mem_write_data !== exp_r.mem_write_data) begin
                    $display("%0t: mem_write_data exp %h got %h", $time,
                             exp_r.mem_write_data, act_r.mem_write_data);
                    error_count++;
                end
                if (act_r.acc !== exp_r.acc) begin
                    $display("%0t: accumulator exp %h got %h", $time, exp_r.acc, act_r.acc);
                    error_count++;
                end
                if (act_r.flags !== exp_r.flags) begin
                    $display("%0t: flags exp %h got %h", $time, exp_r.flags, act_r.flags);
                    error_count++;
                end
                if (act_r.bytes_used !== exp_r.bytes_used) begin
                    $display("%0t: bytes_used exp %0d got %0d", $time, exp_r.bytes_used,
                             act_r.bytes_used);
                    error_count++;
                end
                if (act_r.halted !== exp_r.halted) begin
                    $display("%0t: halted exp %b got %b", $time, exp_r.halted, act_r.halted);
                    error_count++;
                end
                if (act_r.fault !== exp_r.fault) begin
                    $display("%0t: fault exp %0d got %0d", $time, exp_r.fault, act_r.fault);
                    error_count++;
                end
            end
        end
    end

    // Fills registers with bit patterns through immediate loads, then stores to memory and loads A from memory.
    task automatic test_loads_and_memory();
        send_instr(8'h06, 8'hff, 8'h00, 8'h00);  // A <- FF
        send_instr(8'h0e, 8'h00, 8'hff, 8'hff);  // B <- 00
        send_instr(8'h2e, 8'hff, 8'h00, 8'h00);  // H <- FF
        send_instr(8'h36, 8'hff, 8'h00, 8'h00);  // L <- FF
        send_instr(8'h3e, 8'h5a, 8'h00, 8'h00);  // store immediate to memory
        send_instr(8'hf8, 8'h00, 8'h00, 8'h00);  // store A to memory
        send_instr(8'hc7, 8'h00, 8'h00, 8'ha5);  // A <- memory
    endtask

    // Arithmetic and logic group, including carry chains and compare, then rotates, increments and decrements.
    task automatic test_alu_and_rotates();
        for (int k = 0; k < 8; k++)
            send_instr({2'b00, k[2:0], 3'b100}, 8'($urandom), 8'h00, 8'h00);
        send_instr(8'h87, 8'h00, 8'h00, 8'hff);  // add memory
        send_instr(8'h02, 8'h00, 8'h00, 8'h00);  // rotate left
        send_instr(8'h1a, 8'h00, 8'h00, 8'h00);  // rotate right through carry
        send_instr(8'h22, 8'h00, 8'h00, 8'h00);  // undefined rotate
        send_instr(8'h38, 8'h00, 8'h00, 8'h00);  // increment of M is unknown
        send_instr(8'h08, 8'h00, 8'h00, 8'h00);  // increment B
        send_instr(8'h11, 8'h00, 8'h00, 8'h00);  // decrement C
    endtask

    // Calls until the stack overflows, returns until it underflows, then calls from the top of memory.
    task automatic test_stack_limits();
        for (int k = 0; k < STACK_DEPTH + 1; k++)
            send_instr(8'h7e, 8'($urandom), 8'hff, 8'h00);  // unconditional call
        send_instr(8'h3d, 8'h00, 8'h00, 8'h00);  // restart also overflows the full stack
        for (int k = 0; k < STACK_DEPTH + 1; k++) send_instr(8'h07, 8'h00, 8'h00, 8'h00);
        send_instr(8'h44, 8'hff, 8'h3f, 8'h00);  // jump to top of memory
        send_instr(8'h46, 8'hff, 8'h3f, 8'h00);  // return address of the call wraps
        send_instr(8'h07, 8'h00, 8'h00, 8'h00);
    endtask

    // Random instructions; halts are rare so that most items execute.
    task automatic test_random_program(input int n_items);
        logic [7:0] op;
        for (int k = 0; k < n_items; k++) begin
            no_idle = (k >= 400 && k < 600);
            op = 8'($urandom);
            while ((op <= 8'd1 || op == 8'hff) && $urandom_range(99) < 97) op = 8'($urandom);
            // Keep the return stack busy with well-formed call and return pairs.
            if ($urandom_range(9) == 0) op = (cpu_sp < 4) ? 8'h7e : 8'h07;
            send_instr(op, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        no_idle = 1'b0;
    endtask

    // Halt, then show that later instructions are ignored.
    task automatic test_halt();
        send_instr(8'hff, 8'h00, 8'h00, 8'h00);
        send_instr(8'h04, 8'h11, 8'h00, 8'h00);
        send_instr(8'h44, 8'h00, 8'h10, 8'h00);
    endtask

    initial begin
        error_count     = 0;
        no_idle         = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_opcode        = 8'h00;
        i_second_byte   = 8'h00;
        i_third_byte    = 8'h00;
        i_mem_read_data = 8'h00;
        for (int k = 0; k < 7; k++) cpu_regs[k] = 8'h00;
        cpu_pc     = '0;
        cpu_flags  = '0;
        cpu_sp     = 0;
        cpu_halted = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_loads_and_memory();
        test_alu_and_rotates();
        test_stack_limits();
        test_random_program(1550);
        test_halt();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) $display("tb_eight_bit_cpu_execute: PASS");
        else $display("tb_eight_bit_cpu_execute: FAIL");
        $finish;
    end

    // Watchdog well beyond the slowest expected run.
    initial begin
        #2_000_000;
        $display("tb_eight_bit_cpu_execute: FAIL");
        $finish;
    end

endmodule
